// ===== rtl/request_id_slot_table_defines.svh =====
// Assertion macros shared by the request id slot table checkers.
`ifndef REQUEST_ID_SLOT_TABLE_DEFINES_SVH
`define REQUEST_ID_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RIST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("request id slot table check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RIST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("request id slot table check failed");

`endif

// ===== rtl/rist_pkg.sv =====
// Shared types and constants for the request id slot table.
package rist_pkg;

    localparam int ENTRIES_DEFAULT = 32;
    localparam int OP_W            = 2;
    localparam int ID_W            = 16;
    localparam int INDEX_W         = 5;
    localparam int COUNT_W         = 6;

    localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic            found;
    } req_t;

endpackage

// ===== rtl/rist_cell.sv =====
// One slot of the table: holds valid and id, acts on each request passing by.
module rist_cell
    import rist_pkg::*;
#(
    parameter int IDX_W = 5,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  req_t             up,
    input  logic [IDX_W-1:0] up_where,
    output req_t             dn,
    output logic [IDX_W-1:0] dn_where
);

    logic            slot_valid_reg;
    logic            slot_valid_next;
    logic [ID_W-1:0] slot_id_reg;
    logic            dn_valid_reg;
    req_t            dn_req_reg;
    req_t            dn_req_next;
    logic [IDX_W-1:0] dn_where_reg;
    logic            claim_alloc;
    logic            claim_release;
    logic            claim;

    assign claim_alloc   = up.valid && (up.op == OP_ALLOCATE) && !up.found && !slot_valid_reg;
    assign claim_release = up.valid && (up.op == OP_RELEASE) && !up.found && slot_valid_reg
                           && (slot_id_reg == up.id);
    assign claim         = claim_alloc || claim_release;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (claim_alloc)
        begin
            slot_valid_next = 1'b1;
        end
        else if (claim_release || (up.valid && (up.op == OP_CLEAR)))
        begin
            slot_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        dn_req_next       = up;
        dn_req_next.found = up.found || claim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            dn_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            slot_valid_reg <= slot_valid_next;
            dn_valid_reg   <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (claim_alloc)
            begin
                slot_id_reg <= up.id;
            end
            dn_req_reg   <= dn_req_next;
            dn_where_reg <= claim ? IDX_W'(INDEX) : up_where;
        end
    end

    always_comb
    begin
        dn       = dn_req_reg;
        dn.valid = dn_valid_reg;
    end
    assign dn_where = dn_where_reg;

endmodule

// ===== rtl/request_id_slot_table.sv =====
// Top level of the request id slot table: a chain of slot cells and a response stage.
// A request enters the first slot cell and moves one cell per clock unless stalled;
// each cell claims it (allocate into a free slot, release on an id match), clears
// itself on clear-all, or passes it on. The first cell to claim wins, which gives
// lowest-slot priority. After ENTRIES cells the request lands in the response
// register, where the free count is updated, and one request can enter every clock
// while no stall is held. The whole chain holds while a response waits under stall.
module request_id_slot_table
    import rist_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [ID_W-1:0]    request_id,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic               success,
    output logic [INDEX_W-1:0] slot_index,
    output logic [COUNT_W-1:0] free_slots
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    req_t             chain [ENTRIES+1];
    logic [IDX_W-1:0] chain_where [ENTRIES+1];
    logic             advance;

    logic             rsp_valid_reg;
    logic             success_reg;
    logic [IDX_W-1:0] where_reg;
    logic [CNT_W-1:0] free_reg;
    logic [CNT_W-1:0] free_next;
    logic [IDX_W+INDEX_W-1:0] where_ext;
    logic [CNT_W+COUNT_W-1:0] free_ext;
    req_t             last;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !advance;

    assign chain[0].valid = req_valid;
    assign chain[0].op    = operation;
    assign chain[0].id    = request_id;
    assign chain[0].found = 1'b0;
    assign chain_where[0] = '0;

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        rist_cell #(
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .up       (chain[k]),
            .up_where (chain_where[k]),
            .dn       (chain[k+1]),
            .dn_where (chain_where[k+1])
        );
    end

    assign last = chain[ENTRIES];

    always_comb
    begin
        free_next = free_reg;
        case (last.op)
            OP_ALLOCATE: if (last.found) free_next = free_reg - CNT_W'(1);
            OP_RELEASE:  if (last.found) free_next = free_reg + CNT_W'(1);
            OP_CLEAR:    free_next = CNT_W'(ENTRIES);
            default:     free_next = free_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            free_reg      <= CNT_W'(ENTRIES);
        end
        else if (advance)
        begin
            rsp_valid_reg <= last.valid;
            if (last.valid)
            begin
                free_reg <= free_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last.valid)
        begin
            success_reg <= last.found || (last.op == OP_CLEAR);
            where_reg   <= last.found ? chain_where[ENTRIES] : '0;
        end
    end

    assign where_ext  = {{INDEX_W{1'b0}}, where_reg};
    assign free_ext   = {{COUNT_W{1'b0}}, free_reg};
    assign rsp_valid  = rsp_valid_reg;
    assign success    = success_reg;
    assign slot_index = where_ext[INDEX_W-1:0];
    assign free_slots = free_ext[COUNT_W-1:0];

endmodule

// ===== rtl/rist_checker.sv =====
// Port-level checker for the request id slot table, bound to the top level.
`include "request_id_slot_table_defines.svh"

module rist_checker
    import rist_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic [OP_W-1:0]    operation,
    input logic [ID_W-1:0]    request_id,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic               success,
    input logic [INDEX_W-1:0] slot_index,
    input logic [COUNT_W-1:0] free_slots
);

    logic unused_inputs;
    logic [INDEX_W+COUNT_W:0] rsp_payload;
    assign unused_inputs = req_valid ^ (^operation) ^ (^request_id);
    assign rsp_payload   = {success, slot_index, free_slots};

    // a held response keeps its payload
    `RIST_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
    // failed requests report slot zero
    `RIST_ASSERT_NOW(a_fail_index, rsp_valid && !success, slot_index == '0)
    // free count moves only together with a new response
    `RIST_ASSERT_NOW(a_free_moves, !$stable(free_slots), rsp_valid)
    // no request taken while a stalled response is held
    `RIST_ASSERT_NOW(a_stall_back, rsp_valid && rsp_stall, req_stall)

endmodule

bind request_id_slot_table rist_checker u_rist_checker (.*);
